/* rtl/core/svalloc_pkg.sv */
package svalloc_pkg;

  localparam int unsigned VoicesDef   = 8;
  localparam int unsigned TimeBitsDef = 32;

  localparam logic [7:0] FreeMark = 8'hFF;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;

  typedef enum logic {
    ActStart   = 1'b0,
    ActRelease = 1'b1
  } action_e;

  typedef struct packed {
    logic       note_on;
    logic [3:0] channel;
    logic [6:0] pitch;
    logic [6:0] velocity;
  } ev_t;

  typedef struct packed {
    action_e    action;
    logic [2:0] voice;
    logic [6:0] pitch;
    logic [6:0] velocity;
  } cmd_t;

endpackage

/* rtl/core/svalloc_ram.sv */
module svalloc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/core/svalloc_ctrl.sv */
module svalloc_ctrl #(
  parameter int unsigned VOICES    = svalloc_pkg::VoicesDef,
  parameter int unsigned TIME_BITS = svalloc_pkg::TimeBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  svalloc_pkg::ev_t      ev_i,
  input  logic [TIME_BITS-1:0]  time_i,
  input  logic                  mode_i,
  input  logic                  clr_i,
  output logic                  idle_o,
  output logic                  cmd_valid_o,
  output svalloc_pkg::cmd_t     cmd_o,
  input  logic                  cmd_ready_i
);

  localparam int unsigned IW = $clog2(VOICES);
  localparam int unsigned EW = 8 + TIME_BITS;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StScan   = 5'b00010,
    StDrain  = 5'b00100,
    StDecide = 5'b01000,
    StEmit   = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [IW-1:0]        cnt_q, cnt_d;
  logic                 rd_vld_q;
  logic [IW-1:0]        rd_idx_q;
  svalloc_pkg::ev_t     ev_q;
  logic [TIME_BITS-1:0] time_q;
  logic [VOICES-1:0]    pvld_q, svld_q;
  logic                 hit_q;
  logic [IW-1:0]        hit_idx_q;
  logic [IW-1:0]        best_idx_q;
  logic                 best_free_q;
  logic [TIME_BITS-1:0] best_stamp_q;
  logic [7:0]           chp_q;
  logic [TIME_BITS-1:0] chs_q;
  svalloc_pkg::cmd_t    cmd_q, cmd_d;

  logic                 ram_re, ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata, ram_rdata;

  logic [7:0]           pv, evp;
  logic [TIME_BITS-1:0] sv;
  logic                 pfree, better, ch_ok, last;
  logic [IW-1:0]        ch_idx;

  svalloc_ram #(
    .Width(EW),
    .Depth(VOICES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(cnt_q),
    .rdata_o(ram_rdata)
  );

  assign pv     = pvld_q[rd_idx_q] ? ram_rdata[7:0] : svalloc_pkg::FreeMark;
  assign sv     = svld_q[rd_idx_q] ? ram_rdata[EW-1:8] : '0;
  assign pfree  = (pv == svalloc_pkg::FreeMark);
  assign better = (pfree != best_free_q) ? pfree : (sv < best_stamp_q);
  assign evp    = {1'b0, ev_q.pitch};
  assign ch_ok  = ({2'b00, ev_q.channel} < 6'(VOICES));
  assign ch_idx = IW'(ev_q.channel);
  assign last   = (cnt_q == IW'(VOICES - 1));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_d     = cmd_q;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cnt_d   = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        ram_re = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StDecide;
      end
      StDecide: begin
        state_d = StIdle;
        if (mode_i) begin
          if (ch_ok && ev_q.note_on) begin
            ram_we    = 1'b1;
            ram_waddr = ch_idx;
            ram_wdata = {chs_q, evp};
            cmd_d     = '{action: svalloc_pkg::ActStart, voice: 3'(ch_idx),
                          pitch: ev_q.pitch, velocity: ev_q.velocity};
            state_d   = StEmit;
          end else if (ch_ok && (chp_q == evp)) begin
            ram_we    = 1'b1;
            ram_waddr = ch_idx;
            ram_wdata = {chs_q, svalloc_pkg::FreeMark};
            cmd_d     = '{action: svalloc_pkg::ActRelease, voice: 3'(ch_idx),
                          pitch: 7'd0, velocity: 7'd0};
            state_d   = StEmit;
          end
        end else if (ev_q.note_on) begin
          if (!hit_q) begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_q;
            ram_wdata = {time_q, evp};
            cmd_d     = '{action: svalloc_pkg::ActStart, voice: 3'(best_idx_q),
                          pitch: ev_q.pitch, velocity: ev_q.velocity};
            state_d   = StEmit;
          end
        end else if (hit_q) begin
          ram_we    = 1'b1;
          ram_waddr = hit_idx_q;
          ram_wdata = {time_q, svalloc_pkg::FreeMark};
          cmd_d     = '{action: svalloc_pkg::ActRelease, voice: 3'(hit_idx_q),
                        pitch: 7'd0, velocity: 7'd0};
          state_d   = StEmit;
        end
      end
      StEmit: begin
        if (cmd_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      pvld_q   <= '0;
      svld_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= ram_re;
      if (clr_i) begin
        pvld_q <= '0;
      end else if (ram_we) begin
        pvld_q[ram_waddr] <= 1'b1;
      end
      if (ram_we) begin
        svld_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rd_idx_q <= cnt_q;
    if (state_q == StIdle && start_i) begin
      ev_q   <= ev_i;
      time_q <= time_i;
    end
    if (rd_vld_q) begin
      if (rd_idx_q == '0) begin
        hit_q        <= (pv == evp);
        hit_idx_q    <= '0;
        best_idx_q   <= '0;
        best_free_q  <= pfree;
        best_stamp_q <= sv;
      end else begin
        if (!hit_q && (pv == evp)) begin
          hit_q     <= 1'b1;
          hit_idx_q <= rd_idx_q;
        end
        if (better) begin
          best_idx_q   <= rd_idx_q;
          best_free_q  <= pfree;
          best_stamp_q <= sv;
        end
      end
      if (rd_idx_q == ch_idx) begin
        chp_q <= pv;
        chs_q <= sv;
      end
    end
  end

  assign idle_o      = (state_q == StIdle);
  assign cmd_valid_o = (state_q == StEmit);
  assign cmd_o       = cmd_q;

  a_write_in_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == StDecide))
    else $error("table written outside the decision step");

  a_scan_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDecide) |-> !rd_vld_q)
    else $error("read data still in flight at decision");

  a_release_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_o && cmd_o.action == svalloc_pkg::ActRelease)
      |-> (cmd_o.pitch == 7'd0 && cmd_o.velocity == 7'd0))
    else $error("release command carries tone data");

  a_start_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idle_o && start_i) |=> (state_q == StScan))
    else $error("accepted event did not start a scan");

endmodule

/* rtl/core/synth_voice_allocator_top.sv */
// Channel   Direction  Signals                               Payload
// s_axis    in         s_axis_tvalid/tready/tdata/tuser      note event
// m_axis    out        m_axis_tvalid/tready/tdata/tuser      voice command
// cfg       in         cfg_valid_i/cfg_ready_o/cfg_data_i    global mode bit
//
// An event is accepted only while the allocator is idle; it passes through scan, drain and decide,
// then emit when it issues a command, and the scan reads one table entry per cycle.
// A command waits in the output register while the next event is already scanned.
// Reset marks every voice free with a zero stamp at once through per-entry valid bits.
// A stalled output holds the allocator in its emit step until the register frees.
module synth_voice_allocator_top #(
  parameter int unsigned VOICES    = svalloc_pkg::VoicesDef,
  parameter int unsigned TIME_BITS = svalloc_pkg::TimeBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // midi_channel[3:0], pitch[10:4], velocity[17:11], time_now[49:18], zero pad
  input  logic [svalloc_pkg::InDataW-1:0]  s_axis_tdata,
  // note_on[0]
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // voice[2:0], tone_pitch[9:3], tone_velocity[16:10], zero pad
  output logic [svalloc_pkg::OutDataW-1:0] m_axis_tdata,
  // action[0]
  output logic                             m_axis_tuser,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_data_i
);

  logic              mode_q;
  logic              clr;
  logic              idle;
  logic              start;
  logic              cmd_valid, cmd_ready;
  svalloc_pkg::cmd_t cmd, out_q;
  logic              out_vld_q;
  svalloc_pkg::ev_t  ev;

  assign cfg_ready_o = 1'b1;
  assign clr         = cfg_valid_i && (cfg_data_i != mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (clr) begin
        mode_q <= cfg_data_i;
      end
      if (cmd_valid && cmd_ready) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid && cmd_ready) begin
      out_q <= cmd;
    end
  end

  assign cmd_ready     = !out_vld_q || m_axis_tready;
  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid && idle;

  assign ev = '{note_on: s_axis_tuser, channel: s_axis_tdata[3:0],
                pitch: s_axis_tdata[10:4], velocity: s_axis_tdata[17:11]};

  svalloc_ctrl #(
    .VOICES   (VOICES),
    .TIME_BITS(TIME_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .ev_i       (ev),
    .time_i     (TIME_BITS'(s_axis_tdata[49:18])),
    .mode_i     (mode_q),
    .clr_i      (clr),
    .idle_o     (idle),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_ready_i(cmd_ready)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q.velocity, out_q.pitch, out_q.voice};
  assign m_axis_tuser  = out_q.action;

endmodule
